// ===== rtl/gdd_pkg.sv =====
package gdd_pkg;

   localparam int unsigned TIME_W = 64;
   localparam int unsigned CFG_W = 40;
   localparam int unsigned PROG_W = 9;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned NUM_W = CFG_W + PROG_W;

   localparam logic [CFG_W-1:0] DWELL_TIME_RESET = 40'd1000000000;
   localparam logic [CFG_W-1:0] GAP_LIMIT_RESET = 40'd250000000;
   localparam logic [PROG_W-1:0] FULL_CIRCLE = 9'd360;

   localparam logic [CSR_INDEX_W-1:0] CSR_DWELL_TIME = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_LIMIT = 8'd1;

   typedef struct packed {
      logic inside_req;
      logic [TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic fired;
      logic [PROG_W-1:0] progress_degrees;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] dwell_time;
      logic [CFG_W-1:0] gap_limit;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] diff;
      logic borrow;
   } sub_result_type;

   typedef struct packed {
      logic busy;
      logic done;
   } seq_status_type;

endpackage

// ===== rtl/gdd_sub_unit.sv =====
module gdd_sub_unit
   import gdd_pkg::*;
(
   input logic [TIME_W-1:0] op_a,
   input logic [TIME_W-1:0] op_b,
   output sub_result_type result
);

   logic [TIME_W:0] full;

   assign full = {1'b0, op_a} - {1'b0, op_b};
   assign result.diff = full[TIME_W-1:0];
   assign result.borrow = full[TIME_W];

endmodule

// ===== rtl/gdd_seq.sv =====
module gdd_seq
   import gdd_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input req_type req,
   input cfg_type cfg,
   input logic out_free,
   output seq_status_type status,
   output rsp_type rsp
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAP_DIFF,
      ST_GAP_CMP,
      ST_HELD,
      ST_CMP,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic inside_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TIME_W-1:0] last_ff;
   logic [TIME_W-1:0] start_ff;
   logic has_fired_ff;
   logic [TIME_W-1:0] diff_ff;
   logic gap_pre_ff;
   logic neg_ff;
   logic fire_ff;
   logic [PROG_W-1:0] prog_ff;
   logic [NUM_W-1:0] rem_ff;
   logic [NUM_W-1:0] dsh_ff;
   logic [PROG_W-1:0] quot_ff;
   logic [3:0] cnt_ff;

   logic [TIME_W-1:0] op_a;
   logic [TIME_W-1:0] op_b;
   sub_result_type sub;
   logic clear_dwell;
   logic [TIME_W-1:0] start_mid;

   always_comb begin
      unique case (state_ff)
         ST_GAP_DIFF: begin
            op_a = now_ff;
            op_b = last_ff;
         end
         ST_GAP_CMP: begin
            op_a = {{(TIME_W-CFG_W){1'b0}}, cfg.gap_limit};
            op_b = diff_ff;
         end
         ST_HELD: begin
            op_a = now_ff;
            op_b = start_ff;
         end
         ST_CMP: begin
            op_a = diff_ff;
            op_b = {{(TIME_W-CFG_W){1'b0}}, cfg.dwell_time};
         end
         ST_DIV: begin
            op_a = {{(TIME_W-NUM_W){1'b0}}, rem_ff};
            op_b = {{(TIME_W-NUM_W){1'b0}}, dsh_ff};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   gdd_sub_unit u_sub (
      .op_a(op_a),
      .op_b(op_b),
      .result(sub)
   );

   // gap means the limit is below the difference
   assign clear_dwell = !inside_ff || (gap_pre_ff && sub.borrow);
   assign start_mid = clear_dwell ? '0 : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff <= '0;
         start_ff <= '0;
         has_fired_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  inside_ff <= req.inside_req;
                  now_ff <= req.now_time;
                  state_ff <= ST_GAP_DIFF;
               end
            end
            ST_GAP_DIFF: begin
               diff_ff <= sub.diff;
               gap_pre_ff <= (last_ff != '0) && !sub.borrow;
               last_ff <= now_ff;
               state_ff <= ST_GAP_CMP;
            end
            ST_GAP_CMP: begin
               start_ff <= (inside_ff && start_mid == '0) ? now_ff : start_mid;
               if (clear_dwell) begin
                  has_fired_ff <= 1'b0;
               end
               state_ff <= ST_HELD;
            end
            ST_HELD: begin
               diff_ff <= sub.diff;
               neg_ff <= sub.borrow;
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               fire_ff <= inside_ff && !has_fired_ff && !sub.borrow;
               if (inside_ff && !sub.borrow) begin
                  has_fired_ff <= 1'b1;
               end
               if (!inside_ff || start_ff == '0 || neg_ff) begin
                  prog_ff <= '0;
                  state_ff <= ST_DONE;
               end else if (!sub.borrow) begin
                  prog_ff <= FULL_CIRCLE;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               rem_ff <= NUM_W'(diff_ff[CFG_W-1:0]) * NUM_W'(FULL_CIRCLE);
               dsh_ff <= {1'b0, cfg.dwell_time, {(PROG_W-1){1'b0}}};
               quot_ff <= '0;
               cnt_ff <= 4'(PROG_W - 1);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (!sub.borrow) begin
                  rem_ff <= sub.diff[NUM_W-1:0];
               end
               quot_ff <= {quot_ff[PROG_W-2:0], !sub.borrow};
               dsh_ff <= dsh_ff >> 1;
               cnt_ff <= cnt_ff - 4'd1;
               if (cnt_ff == '0) begin
                  prog_ff <= {quot_ff[PROG_W-2:0], !sub.borrow};
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign status.busy = state_ff != ST_IDLE;
   assign status.done = state_ff == ST_DONE;
   assign rsp.fired = fire_ff;
   assign rsp.progress_degrees = prog_ff;

endmodule

// ===== rtl/gaze_dwell_detector_core.sv =====
// an accepted item runs the gap test, the dwell test and, only for partial progress,
// a multiply and a 9-step restoring divide; the shared 64-bit subtractor runs all but
// the multiply, and req_stall holds off a new item until its result is loaded into the output register
// synchronous active-high reset clears dwell state, output valid and sets the
// registers to dwell_time 1000000000 and gap_limit 250000000
module gaze_dwell_detector_core
   import gdd_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_item,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_item,
   input logic csr_write_enable,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CFG_W-1:0] csr_data
);

   cfg_type cfg_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   seq_status_type status;
   rsp_type seq_rsp;
   logic out_free;
   logic start;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign start = req_valid && !status.busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dwell_time <= DWELL_TIME_RESET;
         cfg_ff.gap_limit <= GAP_LIMIT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_DWELL_TIME) begin
            cfg_ff.dwell_time <= csr_data;
         end else if (csr_index == CSR_GAP_LIMIT) begin
            cfg_ff.gap_limit <= csr_data;
         end
      end
   end

   gdd_seq u_seq (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req(req_item),
      .cfg(cfg_ff),
      .out_free(out_free),
      .status(status),
      .rsp(seq_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.done && out_free) begin
         rsp_valid_ff <= 1'b1;
         rsp_ff <= seq_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign req_stall = status.busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

endmodule
